FILE: hw/rtl/trle_pkg.sv
package trle_pkg;

    localparam int unsigned COL_W  = 16;
    localparam int unsigned SUM_W  = COL_W + 1;
    localparam int unsigned STEP_W = $clog2(SUM_W);

    localparam logic [1:0] CFG_RLE_MODE   = 2'd0;
    localparam logic [1:0] CFG_FOUR_BYTE  = 2'd1;
    localparam logic [1:0] CFG_LINE_WIDTH = 2'd2;

    localparam logic [6:0] HDR_COUNT_MASK = 7'h7f;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;
    localparam logic [1:0] LAST_POS_BGR   = 2'd2;
    localparam logic [1:0] LAST_POS_BGRA  = 2'd3;

    typedef struct packed {
        logic       start_image;
        logic [7:0] data_byte;
    } trle_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       row_end;
        logic       row_overrun;
    } trle_out_t;

    typedef struct packed {
        logic             start;
        logic             cancel;
        logic [SUM_W-1:0] dividend;
        logic [COL_W-1:0] divisor;
    } trle_mod_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [COL_W-1:0] remainder;
    } trle_mod_rsp_t;

endpackage

FILE: hw/rtl/trle_col_mod.sv
// Bit-serial remainder of the column sum by the line width, one dividend bit per cycle.
module trle_col_mod (
    input  logic                   clk,
    input  logic                   rst_n,
    input  trle_pkg::trle_mod_req_t req,
    output trle_pkg::trle_mod_rsp_t rsp
);
    import trle_pkg::*;

    logic              busy_reg;
    logic [COL_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  dvd_reg;
    logic [COL_W-1:0]  divisor_reg;
    logic [STEP_W-1:0] step_reg;

    logic [SUM_W-1:0]  trial;
    logic [SUM_W-1:0]  diff;
    logic              fits;
    logic [COL_W-1:0]  rem_next;
    logic              last_step;

    assign trial     = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff      = trial - {1'b0, divisor_reg};
    assign fits      = trial >= {1'b0, divisor_reg};
    assign rem_next  = fits ? diff[COL_W-1:0] : trial[COL_W-1:0];
    assign last_step = step_reg == STEP_W'(SUM_W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (req.cancel)
        begin
            busy_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && last_step)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            dvd_reg     <= req.dividend;
            divisor_reg <= req.divisor;
            step_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= {dvd_reg[SUM_W-2:0], 1'b0};
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = busy_reg && last_step && !req.cancel;
    assign rsp.remainder = rem_next;

endmodule

FILE: hw/rtl/tga_rle_pixel_decoder.sv
// Targa true-color pixel data decoder (image types 2 and 10). Feed it the byte stream
// that follows the header and color map, one byte per src word; set start_image on the
// first byte of an image to clear packet, pixel and column state. In run-length mode each
// packet opens with a header byte (count = bits 6..0 plus one, bit 7 = run). Pixels arrive
// as B,G,R or B,G,R,A; every completed pixel leaves one dst word with RGBA (alpha 255 for
// 24-bit pixels), a repeat count (the packet count for a run, else 1), and row_end /
// row_overrun flags from a column counter that wraps modulo line_width (0 acts as 1).
// Rate: one byte per cycle while src_stall is low. A byte is held in the input register and
// its result is registered in the output register. The column is normally updated in the
// same pass as the result; only when it passes the row end more than once (column + count
// >= 2 * line_width) does a bit-serial remainder unit settle it, and the next pixel-completing
// byte waits in the input register until it finishes. dst_stall backs up into src_stall only
// when the output register is full and the byte in hand completes a pixel. Configuration is
// written through cfg_write_en / cfg_index / cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module tga_rle_pixel_decoder (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    src_valid,
    output logic                    src_stall,
    input  trle_pkg::trle_in_t      src_word,

    output logic                    dst_valid,
    input  logic                    dst_stall,
    output trle_pkg::trle_out_t     dst_word,

    input  logic                    cfg_write_en,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data
);
    import trle_pkg::*;

    // configuration
    logic             rle_mode_reg;
    logic             four_byte_reg;
    logic [COL_W-1:0] line_width_reg;

    // input register
    logic             src_valid_reg;
    trle_in_t         src_word_reg;

    // stream state
    logic             expect_header_reg, expect_header_next;
    logic             packet_is_run_reg, packet_is_run_next;
    logic [7:0]       pixels_left_reg, pixels_left_next;
    logic [1:0]       byte_index_reg, byte_index_next;
    logic [23:0]      pixel_held_reg, pixel_held_next;
    logic [COL_W-1:0] column_reg, column_next;

    // output register
    logic             dst_valid_reg;
    trle_out_t        dst_word_reg, dst_word_next;

    // effective state after an optional start_image clear
    logic             eff_expect;
    logic             eff_run;
    logic [7:0]       eff_left;
    logic [1:0]       eff_index;
    logic [23:0]      eff_held;
    logic [COL_W-1:0] eff_column;

    logic [7:0]       b;
    logic [1:0]       last_pos;
    logic             is_header;
    logic             is_store;
    logic             is_result;
    logic [7:0]       left;
    logic [7:0]       count;
    logic [COL_W-1:0] width;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sum_less_width;
    logic             wrap_none;
    logic             wrap_once;

    logic             src_accept;
    logic             out_free;
    logic             blocked;
    logic             advance;

    trle_mod_req_t    mod_req;
    trle_mod_rsp_t    mod_rsp;

    assign src_accept = src_valid && !src_stall;
    assign b          = src_word_reg.data_byte;

    // start_image clears packet, pixel and column state before the byte is used
    always_comb
    begin
        if (src_word_reg.start_image)
        begin
            eff_expect = 1'b1;
            eff_run    = 1'b0;
            eff_left   = '0;
            eff_index  = '0;
            eff_held   = '0;
            eff_column = '0;
        end
        else
        begin
            eff_expect = expect_header_reg;
            eff_run    = packet_is_run_reg;
            eff_left   = pixels_left_reg;
            eff_index  = byte_index_reg;
            eff_held   = pixel_held_reg;
            eff_column = column_reg;
        end
    end

    assign last_pos  = four_byte_reg ? LAST_POS_BGRA : LAST_POS_BGR;
    assign is_header = rle_mode_reg && eff_expect;
    assign is_store  = !is_header && (eff_index < last_pos);
    assign is_result = !is_header && !is_store;

    // an empty packet still yields one pixel
    assign left  = (eff_left == 8'd0) ? 8'd1 : eff_left;
    assign count = (rle_mode_reg && eff_run) ? left : 8'd1;

    assign width          = (line_width_reg == '0) ? COL_W'(1) : line_width_reg;
    assign sum            = {1'b0, eff_column} + SUM_W'(count);
    assign sum_less_width = sum - {1'b0, width};
    assign wrap_none      = sum < {1'b0, width};
    assign wrap_once      = sum_less_width < {1'b0, width};

    // next packet and pixel state
    always_comb
    begin
        expect_header_next = eff_expect;
        packet_is_run_next = eff_run;
        pixels_left_next   = eff_left;
        byte_index_next    = eff_index;
        pixel_held_next    = eff_held;

        if (is_header)
        begin
            pixels_left_next   = {1'b0, b[6:0] & HDR_COUNT_MASK} + 8'd1;
            packet_is_run_next = b[7];
            expect_header_next = 1'b0;
            byte_index_next    = '0;
        end
        else if (is_store)
        begin
            case (eff_index)
                2'd0:    pixel_held_next[7:0]   = b;
                2'd1:    pixel_held_next[15:8]  = b;
                default: pixel_held_next[23:16] = b;
            endcase
            byte_index_next = eff_index + 2'd1;
        end
        else
        begin
            byte_index_next = '0;
            if (rle_mode_reg)
            begin
                if (eff_run)
                begin
                    pixels_left_next   = '0;
                    expect_header_next = 1'b1;
                end
                else
                begin
                    pixels_left_next   = left - 8'd1;
                    expect_header_next = (left == 8'd1);
                end
            end
        end
    end

    // result word
    always_comb
    begin
        dst_word_next.blue         = eff_held[7:0];
        dst_word_next.green        = eff_held[15:8];
        dst_word_next.red          = four_byte_reg ? eff_held[23:16] : b;
        dst_word_next.alpha        = four_byte_reg ? b : ALPHA_OPAQUE;
        dst_word_next.repeat_count = count;
        dst_word_next.row_end      = !wrap_none;
        dst_word_next.row_overrun  = sum > {1'b0, width};
    end

    // a completing byte needs a free output slot and a settled column
    assign out_free  = !dst_valid_reg || !dst_stall;
    assign blocked   = is_result && (!out_free || mod_rsp.busy);
    assign advance   = src_valid_reg && !blocked;
    assign src_stall = src_valid_reg && !advance;

    // hand multi-wrap runs to the remainder unit; start_image drops any pending work
    assign mod_req.start    = advance && is_result && !wrap_none && !wrap_once;
    assign mod_req.cancel   = advance && src_word_reg.start_image;
    assign mod_req.dividend = sum;
    assign mod_req.divisor  = width;

    trle_col_mod u_col_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    always_comb
    begin
        column_next = column_reg;
        if (advance && src_word_reg.start_image)
        begin
            column_next = '0;
        end
        else if (advance && is_result)
        begin
            column_next = wrap_none ? sum[COL_W-1:0] : sum_less_width[COL_W-1:0];
        end
        else if (mod_rsp.done)
        begin
            column_next = mod_rsp.remainder;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_mode_reg   <= 1'b1;
            four_byte_reg  <= 1'b1;
            line_width_reg <= COL_W'(1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_RLE_MODE:   rle_mode_reg   <= cfg_data[0];
                CFG_FOUR_BYTE:  four_byte_reg  <= cfg_data[0];
                CFG_LINE_WIDTH: line_width_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // input register, stream state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid_reg     <= 1'b0;
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            pixels_left_reg   <= '0;
            byte_index_reg    <= '0;
            pixel_held_reg    <= '0;
            column_reg        <= '0;
            dst_valid_reg     <= 1'b0;
        end
        else
        begin
            if (src_accept)
            begin
                src_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                src_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                expect_header_reg <= expect_header_next;
                packet_is_run_reg <= packet_is_run_next;
                pixels_left_reg   <= pixels_left_next;
                byte_index_reg    <= byte_index_next;
                pixel_held_reg    <= pixel_held_next;
            end
            column_reg <= column_next;

            if (advance && is_result)
            begin
                dst_valid_reg <= 1'b1;
            end
            else if (!dst_stall)
            begin
                dst_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (src_accept)
        begin
            src_word_reg <= src_word;
        end
        if (advance && is_result)
        begin
            dst_word_reg <= dst_word_next;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_word  = dst_word_reg;

endmodule

FILE: hw/rtl/trle_checker.sv
module trle_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                dst_valid,
    input  logic                dst_stall,
    input  trle_pkg::trle_out_t dst_word
);
    import trle_pkg::*;

    // hold a stalled result word
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(dst_word))
        else $error("dst word changed while stalled");

    // repeat count stays within one packet
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (dst_word.repeat_count != 8'd0) && (dst_word.repeat_count <= 8'd128))
        else $error("repeat count out of range");

    // an overrun always reaches the row end
    a_overrun_end: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_word.row_overrun |-> dst_word.row_end)
        else $error("row overrun without row end");

    // result valid is always driven out of reset
    a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(dst_valid))
        else $error("dst valid unknown");

endmodule

bind tga_rle_pixel_decoder trle_checker u_trle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
);
